// File: sv/mnss_pkg.sv
// Shared types, constants and a helper function of the Manhattan nearest-site search.
package mnss_pkg;

    localparam int MAX_SITES  = 64;
    localparam int COORD_BITS = 16;

    localparam int IDX_BITS = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_BITS = $clog2(MAX_SITES + 1);
    localparam int DIST_W   = COORD_BITS + 1;
    localparam int SUM_W    = DIST_W + CNT_BITS;

    localparam int TYPE_W   = 2;
    localparam int FIELD_W  = 16;
    localparam int STAT_W   = 2;
    localparam int NIDX_W   = 6;
    localparam int MIND_W   = 17;
    localparam int DSUM_W   = 23;
    localparam int LIMIT_W  = 24;
    localparam int CMP_W    = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [MIND_W-1:0]  MIND_MAX         = '1;
    localparam logic [DSUM_W-1:0]  DSUM_MAX         = '1;
    localparam logic [LIMIT_W-1:0] SUM_LIMIT_RESET  = 24'd10000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0]         req_type;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NIDX_W-1:0] nearest_index;
        logic              is_tie;
        logic [MIND_W-1:0] min_distance;
        logic [DSUM_W-1:0] distance_sum;
        logic              within_limit;
    } rsp_t;

    // Travels alongside each site read through the distance pipeline.
    typedef struct packed {
        logic                vld;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } tag_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] d;
        d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
        if (d < 0)
        begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

endpackage

// File: sv/mnss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mnss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mnss_dist.sv
// Shared distance unit: one registered Manhattan distance per cycle.
module mnss_dist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mnss_pkg::coord_t                     px,
    input  mnss_pkg::coord_t                     py,
    input  logic [2*mnss_pkg::COORD_BITS-1:0]    site,
    input  mnss_pkg::tag_t                       tag_in,
    output logic [mnss_pkg::DIST_W-1:0]          dist_val,
    output mnss_pkg::tag_t                       tag_out
);

    mnss_pkg::coord_t                  sx;
    mnss_pkg::coord_t                  sy;
    logic [mnss_pkg::DIST_W-1:0]       dist_next;
    logic [mnss_pkg::DIST_W-1:0]       dist_reg;
    mnss_pkg::tag_t                    tag_reg;

    // Site word is packed as {y, x}.
    assign sx = site[mnss_pkg::COORD_BITS-1:0];
    assign sy = site[2*mnss_pkg::COORD_BITS-1:mnss_pkg::COORD_BITS];

    assign dist_next = mnss_pkg::DIST_W'(mnss_pkg::abs_diff(px, sx))
                     + mnss_pkg::DIST_W'(mnss_pkg::abs_diff(py, sy));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign dist_val = dist_reg;
    assign tag_out  = tag_reg;

endmodule

// File: sv/manhattan_nearest_site_search.sv
// Top level: site table, scan sequencer and result register of the nearest-site search.
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ----------------------------------
//  request   start, busy, req                    taken when start is high, busy low
//  result    done, rsp                           done high for one cycle per result
//  config    sum_limit_we, sum_limit_wdata       written when sum_limit_we is high
//
// Clear, append and unknown requests give their result the cycle after they are
// taken, and busy stays low. A query holds busy while the one distance unit takes
// one site per cycle from the site RAM's read port, and through the read, distance
// and report stages. Reset empties the table and loads the default limit; site
// RAM contents are not cleared. The receiver cannot stall.
module manhattan_nearest_site_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mnss_pkg::req_t                    req,
    output logic                              done,
    output mnss_pkg::rsp_t                    rsp,
    input  logic                              sum_limit_we,
    input  logic [mnss_pkg::LIMIT_W-1:0]      sum_limit_wdata
);

    localparam int RAM_W = 2 * mnss_pkg::COORD_BITS;

    mnss_pkg::state_t                  state_reg,  state_next;
    logic [mnss_pkg::CNT_BITS-1:0]     count_reg,  count_next;
    logic [mnss_pkg::CNT_BITS-1:0]     issue_reg,  issue_next;
    mnss_pkg::tag_t                    rd_tag_reg, rd_tag_next;
    logic                              done_reg,   done_next;
    logic [mnss_pkg::LIMIT_W-1:0]      limit_reg;

    mnss_pkg::coord_t                  px_reg,     px_next;
    mnss_pkg::coord_t                  py_reg,     py_next;
    logic [mnss_pkg::DIST_W-1:0]       best_reg,   best_next;
    logic [mnss_pkg::IDX_BITS-1:0]     bidx_reg,   bidx_next;
    logic                              tie_reg,    tie_next;
    logic [mnss_pkg::SUM_W-1:0]        sum_reg,    sum_next;
    mnss_pkg::rsp_t                    rsp_reg,    rsp_next;

    logic                              ram_we;
    logic [mnss_pkg::IDX_BITS-1:0]     ram_waddr;
    logic [RAM_W-1:0]                  ram_wdata;
    logic [mnss_pkg::IDX_BITS-1:0]     ram_raddr;
    logic [RAM_W-1:0]                  ram_rdata;

    logic [mnss_pkg::DIST_W-1:0]       site_dist;
    mnss_pkg::tag_t                    dist_tag;

    mnss_pkg::coord_t                  in_x;
    mnss_pkg::coord_t                  in_y;

    assign in_x = req.coord_x[mnss_pkg::COORD_BITS-1:0];
    assign in_y = req.coord_y[mnss_pkg::COORD_BITS-1:0];

    mnss_ram #(
        .WIDTH (RAM_W),
        .DEPTH (mnss_pkg::MAX_SITES)
    ) u_site_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mnss_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .px       (px_reg),
        .py       (py_reg),
        .site     (ram_rdata),
        .tag_in   (rd_tag_reg),
        .dist_val (site_dist),
        .tag_out  (dist_tag)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        rd_tag_next = '0;
        done_next   = 1'b0;
        px_next     = px_reg;
        py_next     = py_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        tie_next    = tie_reg;
        sum_next    = sum_reg;
        rsp_next    = rsp_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[mnss_pkg::IDX_BITS-1:0];
        ram_wdata   = {in_y, in_x};
        ram_raddr   = issue_reg[mnss_pkg::IDX_BITS-1:0];

        case (state_reg)
            mnss_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    rsp_next  = '0;
                    done_next = 1'b1;
                    case (req.req_type)
                        mnss_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        mnss_pkg::REQ_APPEND:
                        begin
                            if (count_reg >= mnss_pkg::CNT_BITS'(mnss_pkg::MAX_SITES))
                            begin
                                rsp_next.status = mnss_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        mnss_pkg::REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = mnss_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // Hold the result until the scan reports.
                                done_next  = 1'b0;
                                rsp_next   = rsp_reg;
                                px_next    = in_x;
                                py_next    = in_y;
                                issue_next = '0;
                                state_next = mnss_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unknown request: leave state alone.
                        end
                    endcase
                end
            end

            mnss_pkg::ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_tag_next.vld  = 1'b1;
                    rd_tag_next.last = (issue_reg == count_reg - 1'b1);
                    rd_tag_next.idx  = issue_reg[mnss_pkg::IDX_BITS-1:0];
                    issue_next       = issue_reg + 1'b1;
                end

                if (dist_tag.vld)
                begin
                    if (dist_tag.idx == '0)
                    begin
                        best_next = site_dist;
                        bidx_next = dist_tag.idx;
                        tie_next  = 1'b0;
                        sum_next  = mnss_pkg::SUM_W'(site_dist);
                    end
                    else
                    begin
                        sum_next = sum_reg + mnss_pkg::SUM_W'(site_dist);
                        if (site_dist < best_reg)
                        begin
                            best_next = site_dist;
                            bidx_next = dist_tag.idx;
                            tie_next  = 1'b0;
                        end
                        else if (site_dist == best_reg)
                        begin
                            tie_next = 1'b1;
                        end
                    end
                    if (dist_tag.last)
                    begin
                        state_next = mnss_pkg::ST_REPORT;
                    end
                end
            end

            mnss_pkg::ST_REPORT:
            begin
                rsp_next.status        = mnss_pkg::STAT_OK;
                rsp_next.nearest_index = mnss_pkg::NIDX_W'(bidx_reg);
                rsp_next.is_tie        = tie_reg;
                rsp_next.min_distance  =
                    (best_reg > mnss_pkg::DIST_W'(mnss_pkg::MIND_MAX)) ?
                    mnss_pkg::MIND_MAX : mnss_pkg::MIND_W'(best_reg);
                rsp_next.distance_sum  =
                    (sum_reg > mnss_pkg::SUM_W'(mnss_pkg::DSUM_MAX)) ?
                    mnss_pkg::DSUM_MAX : mnss_pkg::DSUM_W'(sum_reg);
                // Compare the exact sum, not the saturated one.
                rsp_next.within_limit  =
                    (mnss_pkg::CMP_W'(sum_reg) < mnss_pkg::CMP_W'(limit_reg));
                done_next  = 1'b1;
                state_next = mnss_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mnss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mnss_pkg::ST_IDLE;
            count_reg  <= '0;
            issue_reg  <= '0;
            rd_tag_reg <= '0;
            done_reg   <= 1'b0;
            limit_reg  <= mnss_pkg::SUM_LIMIT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            rd_tag_reg <= rd_tag_next;
            done_reg   <= done_next;
            if (sum_limit_we)
            begin
                limit_reg <= sum_limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        tie_reg  <= tie_next;
        sum_reg  <= sum_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != mnss_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mnss_pkg::ST_SCAN |-> count_reg != '0)
        else $error("scan running over an empty table");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mnss_pkg::ST_SCAN |-> issue_reg <= count_reg)
        else $error("read issue ran past the site count");

    a_tag_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_tag.vld |-> state_reg == mnss_pkg::ST_SCAN)
        else $error("distance arrived outside a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mnss_pkg::CNT_BITS'(mnss_pkg::MAX_SITES))
        else $error("site count beyond table depth");

    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mnss_pkg::ST_REPORT |=> done && !busy)
        else $error("report did not deliver a transaction");

endmodule
